@@ hdl/gcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Great circle distance package
// Shared constants, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gcd_pkg;

	// Longest CORDIC run that the arctangent table supports.
	localparam int unsigned ATAN_LEN = 40;

	// One full turn and half a turn in units of 1e-7 degree.
	localparam logic [31:0] DEG_TURN = 32'd3600000000;
	localparam logic [31:0] DEG_HALF = 32'd1800000000;

	// CORDIC gain compensation, Q30.
	localparam logic signed [31:0] CORDIC_K = 32'sd652032874;

	// 2*pi in Q29.
	localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

	// Reset value of the radius register.
	localparam logic [22:0] RADIUS_RESET = 23'd6371000;

	// Binary angle, 2^32 is a full turn.
	typedef logic [31:0] turn_t;

	// Q30 fixed point value.
	typedef logic signed [31:0] q30_t;

	// atan(2^-i) as a binary angle.
	function automatic logic [29:0] atan_turn(input int unsigned i);
		logic [29:0] r;
		case (i)
			0: r = 30'h20000000;
			1: r = 30'h12E4051E;
			2: r = 30'h09FB385B;
			3: r = 30'h051111D4;
			4: r = 30'h028B0D43;
			5: r = 30'h0145D7E1;
			6: r = 30'h00A2F61E;
			7: r = 30'h00517C55;
			8: r = 30'h0028BE53;
			9: r = 30'h00145F2F;
			10: r = 30'h000A2F98;
			11: r = 30'h000517CC;
			12: r = 30'h00028BE6;
			13: r = 30'h000145F3;
			14: r = 30'h0000A2FA;
			15: r = 30'h0000517D;
			16: r = 30'h000028BE;
			17: r = 30'h0000145F;
			18: r = 30'h00000A30;
			19: r = 30'h00000518;
			20: r = 30'h0000028C;
			21: r = 30'h00000146;
			22: r = 30'h000000A3;
			23: r = 30'h00000051;
			24: r = 30'h00000029;
			25: r = 30'h00000014;
			26: r = 30'h0000000A;
			27: r = 30'h00000005;
			28: r = 30'h00000003;
			29: r = 30'h00000001;
			30: r = 30'h00000001;
			default: r = 30'h00000000;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/great_circle_distance.sv @@
// An accepted input beat reaches its output beat through the turn converter,
// the two CORDIC pipelines and the square root pipeline, one step per stage.
// Throughput: one point pair per cycle; the whole pipeline holds while an
// output beat waits and the output register is full.
// Reset clears all valid bits and loads the radius register with 6371000.
// ----------------------------------------------------------------------------
// Great circle distance
// Spherical law of cosines distance between two points given in 1e-7
// degree, pipelined end to end.
// ----------------------------------------------------------------------------
module great_circle_distance #(
	parameter int CORDIC_STEPS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // lat_a[30:0], lon_a[62:31], lat_b[93:63], lon_b[125:94]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,   // distance[24:0]
	input  logic         cfg_we,
	input  logic [22:0]  cfg_wdata
);

	logic en;

	logic [22:0] radius_q;

	logic           turn_valid;
	gcd_pkg::turn_t la;
	gcd_pkg::turn_t lb;
	gcd_pkg::turn_t dlon;
	gcd_pkg::turn_t ang3 [3];

	logic          sc_valid;
	gcd_pkg::q30_t cos_v [3];
	gcd_pkg::q30_t sin_v [3];

	logic          cosc_valid;
	gcd_pkg::q30_t cosc;

	logic          root_valid;
	gcd_pkg::q30_t root_cosc;
	logic [30:0]   sinc;

	logic           acos_valid;
	gcd_pkg::turn_t ang;

	logic [63:0] rad_prod;
	logic [54:0] dist_prod;

	logic        vld_s1;
	logic [30:0] rad_s1;
	logic        vld_s2;
	logic [24:0] distance_s2;

	// Every stage moves together; the pipeline holds only when the output
	// register is full and not being taken.
	assign en       = !vld_s2 || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= gcd_pkg::RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	gcd_turns u_turns (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.lat_a     ($signed(s_tdata[30:0])),
		.lon_a     ($signed(s_tdata[62:31])),
		.lat_b     ($signed(s_tdata[93:63])),
		.lon_b     ($signed(s_tdata[125:94])),
		.out_valid (turn_valid),
		.la        (la),
		.lb        (lb),
		.dlon      (dlon)
	);

	assign ang3[0] = la;
	assign ang3[1] = lb;
	assign ang3[2] = dlon;

	gcd_sincos #(
		.STEPS (CORDIC_STEPS)
	) u_sincos (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (turn_valid),
		.ang       (ang3),
		.out_valid (sc_valid),
		.cos_v     (cos_v),
		.sin_v     (sin_v)
	);

	gcd_cosc u_cosc (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sc_valid),
		.cos_a     (cos_v[0]),
		.cos_b     (cos_v[1]),
		.cos_d     (cos_v[2]),
		.sin_a     (sin_v[0]),
		.sin_b     (sin_v[1]),
		.out_valid (cosc_valid),
		.cosc      (cosc)
	);

	gcd_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cosc_valid),
		.cosc      (cosc),
		.out_valid (root_valid),
		.cosc_out  (root_cosc),
		.sinc      (sinc)
	);

	gcd_acos #(
		.STEPS (CORDIC_STEPS)
	) u_acos (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (root_valid),
		.cosc      (root_cosc),
		.sinc      (sinc),
		.out_valid (acos_valid),
		.ang       (ang)
	);

	// Binary angle to Q29 radians, then radians times radius, each rounded.
	assign rad_prod  = ang * gcd_pkg::TWO_PI_Q29;
	assign dist_prod = rad_s1 * radius_q + 55'd268435456;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= acos_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1      <= 31'((rad_prod + 64'd2147483648) >> 32);
			distance_s2 <= dist_prod[53:29];
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {7'd0, distance_s2};

endmodule

@@ hdl/gcd_turns.sv @@
// ----------------------------------------------------------------------------
// Degree to binary angle converter
// Reduces four coordinates modulo a full turn and scales them to 32-bit
// binary angles with a reciprocal multiply and a one-step remainder correction.
// ----------------------------------------------------------------------------
module gcd_turns (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [30:0]   lat_a,
	input  logic signed [31:0]   lon_a,
	input  logic signed [30:0]   lat_b,
	input  logic signed [31:0]   lon_b,
	output logic                 out_valid,
	output gcd_pkg::turn_t       la,
	output gcd_pkg::turn_t       lb,
	output gcd_pkg::turn_t       dlon
);

	localparam int LANES = 4;

	// Nearest integer to 2^63 / 3600000000. The quotient estimate it gives
	// is never more than one away from the exact rounded quotient.
	localparam logic [31:0] RECIP = 32'd2562047788;

	logic signed [32:0] ext [LANES];
	logic [31:0]        xm  [LANES];
	logic [33:0]        qd  [LANES];

	logic        vld_s1;
	logic [31:0] xm_s1 [LANES];

	logic        vld_s2;
	logic [63:0] prod_s2 [LANES];
	logic [1:0]  xlo_s2  [LANES];

	logic        vld_s3;
	logic [32:0] qe_s3  [LANES];
	logic [1:0]  xlo_s3 [LANES];

	logic        vld_s4;
	logic [32:0] qe_s4  [LANES];
	logic [33:0] rem_s4 [LANES];

	logic        vld_s5;
	logic [31:0] q_s5 [LANES];

	logic           vld_s6;
	gcd_pkg::turn_t la_s6;
	gcd_pkg::turn_t lb_s6;
	gcd_pkg::turn_t dlon_s6;

	// A negative coordinate is brought into range by one added turn; the
	// input widths never need more than that.
	always_comb begin
		ext[0] = 33'(lat_a);
		ext[1] = 33'(lon_a);
		ext[2] = 33'(lat_b);
		ext[3] = 33'(lon_b);
		for (int l = 0; l < LANES; l++) begin
			if (ext[l][32]) begin
				xm[l] = 32'(ext[l] + $signed({1'b0, gcd_pkg::DEG_TURN}));
			end else begin
				xm[l] = ext[l][31:0];
			end
		end
	end

	// The remainder of xm * 2^32 + half a turn against the estimate lies
	// within two turns of zero, so only its low 34 bits are formed.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			qd[l] = qe_s3[l] * {2'b00, gcd_pkg::DEG_TURN};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				xm_s1[l]   <= xm[l];
				prod_s2[l] <= xm_s1[l] * RECIP;
				xlo_s2[l]  <= xm_s1[l][1:0];
				qe_s3[l]   <= 33'((prod_s2[l] + 64'd1073741824) >> 31);
				xlo_s3[l]  <= xlo_s2[l];
				qe_s4[l]   <= qe_s3[l];
				rem_s4[l]  <= {xlo_s3[l], gcd_pkg::DEG_HALF} - qd[l];
				if (rem_s4[l][33]) begin
					q_s5[l] <= 32'(qe_s4[l] - 33'd1);
				end else if (rem_s4[l] >= {2'b00, gcd_pkg::DEG_TURN}) begin
					q_s5[l] <= 32'(qe_s4[l] + 33'd1);
				end else begin
					q_s5[l] <= qe_s4[l][31:0];
				end
			end
		end
	end

	// The longitude difference wraps modulo a full turn.
	always_ff @(posedge clk) begin
		if (en) begin
			la_s6   <= q_s5[0];
			lb_s6   <= q_s5[2];
			dlon_s6 <= q_s5[1] - q_s5[3];
		end
	end

	assign out_valid = vld_s6;
	assign la        = la_s6;
	assign lb        = lb_s6;
	assign dlon      = dlon_s6;

endmodule

@@ hdl/gcd_sincos.sv @@
// ----------------------------------------------------------------------------
// Sine and cosine unit
// Three rotation-mode CORDIC lanes, one micro-rotation per pipeline stage.
// ----------------------------------------------------------------------------
module gcd_sincos #(
	parameter int STEPS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  gcd_pkg::turn_t ang [3],
	output logic           out_valid,
	output gcd_pkg::q30_t  cos_v [3],
	output gcd_pkg::q30_t  sin_v [3]
);

	localparam int LANES = 3;

	gcd_pkg::turn_t shifted_ang [LANES];
	logic           flip        [LANES];

	logic                vld_s  [STEPS+1];
	logic signed [31:0]  x_s    [STEPS+1][LANES];
	logic signed [31:0]  y_s    [STEPS+1][LANES];
	logic signed [31:0]  z_s    [STEPS+1][LANES];
	logic                flip_s [STEPS+1][LANES];

	logic          vld_out_s;
	gcd_pkg::q30_t cos_s [LANES];
	gcd_pkg::q30_t sin_s [LANES];

	// Angles in the left half plane are turned by half a turn and the
	// results negated, so the CORDIC only sees -90 to +90 degrees.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			flip[l] = (ang[l] + 32'h40000000) >= 32'h80000000;
			shifted_ang[l] = flip[l] ? ang[l] + 32'h80000000 : ang[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				x_s[0][l]    <= gcd_pkg::CORDIC_K;
				y_s[0][l]    <= '0;
				z_s[0][l]    <= $signed(shifted_ang[l]);
				flip_s[0][l] <= flip[l];
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		localparam logic signed [31:0] ATAN = $signed({2'b00, gcd_pkg::atan_turn(i)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					if (!z_s[i][l][31]) begin
						x_s[i+1][l] <= x_s[i][l] - (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] + (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] - ATAN;
					end else begin
						x_s[i+1][l] <= x_s[i][l] + (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] - (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] + ATAN;
					end
					flip_s[i+1][l] <= flip_s[i][l];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_s <= 1'b0;
		end else if (en) begin
			vld_out_s <= vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				cos_s[l] <= flip_s[STEPS][l] ? -x_s[STEPS][l] : x_s[STEPS][l];
				sin_s[l] <= flip_s[STEPS][l] ? -y_s[STEPS][l] : y_s[STEPS][l];
			end
		end
	end

	assign out_valid = vld_out_s;
	assign cos_v     = cos_s;
	assign sin_v     = sin_s;

endmodule

@@ hdl/gcd_cosc.sv @@
// ----------------------------------------------------------------------------
// Central angle cosine
// Forms cos(a)cos(b)cos(d) + sin(a)sin(b) in Q30 over three stages and
// clamps it to [-1, 1].
// ----------------------------------------------------------------------------
module gcd_cosc (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  gcd_pkg::q30_t cos_a,
	input  gcd_pkg::q30_t cos_b,
	input  gcd_pkg::q30_t cos_d,
	input  gcd_pkg::q30_t sin_a,
	input  gcd_pkg::q30_t sin_b,
	output logic          out_valid,
	output gcd_pkg::q30_t cosc
);

	localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;

	logic signed [63:0] prod_cc;
	logic signed [63:0] prod_ss;
	logic signed [65:0] prod_ccd;
	logic signed [34:0] sum;

	logic               vld_s1;
	logic signed [33:0] cc_s1;
	logic signed [33:0] ss_s1;
	gcd_pkg::q30_t      cd_s1;

	logic               vld_s2;
	logic signed [33:0] ccd_s2;
	logic signed [33:0] ss_s2;

	logic               vld_s3;
	gcd_pkg::q30_t      cosc_s3;

	// Each product is rounded back to Q30 by adding half an LSB and
	// shifting with floor.
	always_comb begin
		prod_cc  = cos_a * cos_b;
		prod_ss  = sin_a * sin_b;
		prod_ccd = cc_s1 * cd_s1;
		sum      = 35'(ccd_s2) + 35'(ss_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s1  <= 34'((prod_cc + 64'sd536870912) >>> 30);
			ss_s1  <= 34'((prod_ss + 64'sd536870912) >>> 30);
			cd_s1  <= cos_d;
			ccd_s2 <= 34'((prod_ccd + 66'sd536870912) >>> 30);
			ss_s2  <= ss_s1;
			if (sum > ONE_Q30) begin
				cosc_s3 <= 32'(ONE_Q30);
			end else if (sum < -ONE_Q30) begin
				cosc_s3 <= 32'(-ONE_Q30);
			end else begin
				cosc_s3 <= 32'(sum);
			end
		end
	end

	assign out_valid = vld_s3;
	assign cosc      = cosc_s3;

endmodule

@@ hdl/gcd_isqrt.sv @@
// ----------------------------------------------------------------------------
// Sine from cosine
// Computes floor(sqrt(2^60 - c^2)) with a pipelined digit-by-digit square
// root, one result bit per stage, and carries c alongside.
// ----------------------------------------------------------------------------
module gcd_isqrt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  gcd_pkg::q30_t cosc,
	output logic          out_valid,
	output gcd_pkg::q30_t cosc_out,
	output logic [30:0]   sinc
);

	localparam int STEPS = 31;
	localparam logic [60:0] ONE_SQ = 61'd1 << 60;

	logic [31:0] mag;

	logic          vld_sq_s;
	logic [61:0]   sq_s;
	gcd_pkg::q30_t c_sq_s;

	logic          vld_s [STEPS+1];
	logic [60:0]   v_s   [STEPS+1];
	logic [61:0]   res_s [STEPS+1];
	gcd_pkg::q30_t c_s   [STEPS+1];

	assign mag = cosc[31] ? 32'(-cosc) : 32'(cosc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sq_s <= 1'b0;
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_sq_s <= in_valid;
			vld_s[0] <= vld_sq_s;
		end
	end

	// c is clamped to one in magnitude, so c^2 never exceeds 2^60.
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s     <= mag[30:0] * mag[30:0];
			c_sq_s   <= cosc;
			v_s[0]   <= ONE_SQ - sq_s[60:0];
			res_s[0] <= '0;
			c_s[0]   <= c_sq_s;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_root
		localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
		logic [61:0] trial;

		assign trial = res_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (62'(v_s[k]) >= trial) begin
					v_s[k+1]   <= 61'(62'(v_s[k]) - trial);
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					v_s[k+1]   <= v_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
				c_s[k+1] <= c_s[k];
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign cosc_out  = c_s[STEPS];
	assign sinc      = res_s[STEPS][30:0];

endmodule

@@ hdl/gcd_acos.sv @@
// ----------------------------------------------------------------------------
// Arccosine unit
// Vectoring-mode CORDIC on the vector (c, s), one micro-rotation per stage,
// giving the central angle as a binary angle clamped to half a turn.
// ----------------------------------------------------------------------------
module gcd_acos #(
	parameter int STEPS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  gcd_pkg::q30_t  cosc,
	input  logic [30:0]    sinc,
	output logic           out_valid,
	output gcd_pkg::turn_t ang
);

	localparam logic signed [32:0] QUARTER = 33'sd1073741824;
	localparam logic signed [32:0] HALF    = 33'sd2147483648;

	logic               vld_s [STEPS+1];
	logic signed [32:0] x_s   [STEPS+1];
	logic signed [32:0] y_s   [STEPS+1];
	logic signed [32:0] z_s   [STEPS+1];

	logic           vld_out_s;
	gcd_pkg::turn_t ang_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	// A negative cosine starts from the vector turned back by a quarter turn.
	always_ff @(posedge clk) begin
		if (en) begin
			if (!cosc[31]) begin
				x_s[0] <= 33'(cosc);
				y_s[0] <= $signed({2'b00, sinc});
				z_s[0] <= '0;
			end else begin
				x_s[0] <= $signed({2'b00, sinc});
				y_s[0] <= -33'(cosc);
				z_s[0] <= QUARTER;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_vec
		localparam logic signed [32:0] ATAN = $signed({3'b000, gcd_pkg::atan_turn(i)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 33'sd0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_s <= 1'b0;
		end else if (en) begin
			vld_out_s <= vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_s[STEPS][32]) begin
				ang_s <= '0;
			end else if (z_s[STEPS] > HALF) begin
				ang_s <= 32'(HALF);
			end else begin
				ang_s <= z_s[STEPS][31:0];
			end
		end
	end

	assign out_valid = vld_out_s;
	assign ang       = ang_s;

endmodule

@@ dv/great_circle_distance_tb.sv @@
// ----------------------------------------------------------------------------
// Great circle distance testbench
// Streams point pairs through the block with random gaps and back pressure,
// and checks each distance beat against a fixed-point predictor of the
// spherical law of cosines or a given value. The radius register is changed between phases.
// ----------------------------------------------------------------------------
module great_circle_distance_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = 32;
	localparam longint NO_CHECK = -1;
	localparam int LAT_MAX = 900000000;
	localparam int LON_MAX = 1800000000;

	typedef struct {
		int lat_a;
		int lon_a;
		int lat_b;
		int lon_b;
	} point_pair_t;

	typedef struct {
		bit          is_cfg;
		logic [22:0] radius;
		point_pair_t pair;
		longint      want;
	} stim_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;   // lat_a[30:0], lon_a[62:31], lat_b[93:63], lon_b[125:94]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;        // distance[24:0]
	logic         cfg_we = 1'b0;
	logic [22:0]  cfg_wdata = '0;

	logic [22:0]  radius_now = gcd_pkg::RADIUS_RESET;
	logic [24:0]  dist_queue[$];
	int           errors = 0;
	bit           send_quiet = 1'b0;
	bit           recv_quiet = 1'b0;
	bit           recv_hold = 1'b0;
	bit           hold_go = 1'b0;

	great_circle_distance #(.CORDIC_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic gcd_pkg::turn_t deg_to_turn(longint x);
		longint r;
		longint unsigned xm;
		longint unsigned q;
		r = x % longint'(gcd_pkg::DEG_TURN);
		if (r < 0) begin
			r += longint'(gcd_pkg::DEG_TURN);
		end
		xm = longint'(r);
		q = ((xm << 32) + longint'(gcd_pkg::DEG_HALF)) / longint'(gcd_pkg::DEG_TURN);
		return q[31:0];
	endfunction

	function automatic longint round_q30(longint a, longint b);
		return (a * b + 64'sd536870912) >>> 30;
	endfunction

	function automatic void rotate(gcd_pkg::turn_t a, output longint c, output longint s);
		bit flip;
		longint x, y, z, nx;
		gcd_pkg::turn_t sum;
		flip = 1'b0;
		x = longint'(gcd_pkg::CORDIC_K);
		y = 0;
		sum = a + 32'h40000000;
		if (sum >= 32'h80000000) begin
			a = a + 32'h80000000;
			flip = 1'b1;
		end
		z = longint'(signed'(a));
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(gcd_pkg::atan_turn(i));
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(gcd_pkg::atan_turn(i));
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bits;
		res = 0;
		bits = 64'd1 << 62;
		while (bits > v) begin
			bits >>= 2;
		end
		while (bits != 0) begin
			if (v >= res + bits) begin
				v -= res + bits;
				res = (res >> 1) + bits;
			end else begin
				res >>= 1;
			end
			bits >>= 2;
		end
		return res;
	endfunction

	// Vectoring CORDIC on (c, sqrt(1-c^2)) gives the arccosine as a binary angle.
	function automatic longint acos_turn(longint c);
		longint x, y, z, nx, s;
		s = longint'(int_sqrt((64'd1 << 60) - longint'(c * c)));
		if (c >= 0) begin
			x = c; y = s; z = 0;
		end else begin
			x = s; y = -c; z = 64'sd1073741824;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(gcd_pkg::atan_turn(i));
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(gcd_pkg::atan_turn(i));
			end
			x = nx;
		end
		if (z < 0) z = 0;
		if (z > 64'sd2147483648) z = 64'sd2147483648;
		return z;
	endfunction

	function automatic logic [24:0] gc_distance(point_pair_t p, logic [22:0] radius);
		logic signed [30:0] la, lb;
		logic signed [31:0] oa, ob;
		longint ca, sa, cb, sb, cd, sd, c;
		longint unsigned ang, rad, d;
		la = p.lat_a[30:0];
		lb = p.lat_b[30:0];
		oa = p.lon_a;
		ob = p.lon_b;
		rotate(deg_to_turn(la), ca, sa);
		rotate(deg_to_turn(lb), cb, sb);
		rotate(deg_to_turn(oa) - deg_to_turn(ob), cd, sd);
		c = round_q30(round_q30(ca, cb), cd) + round_q30(sa, sb);
		if (c > 64'sd1073741824) c = 64'sd1073741824;
		if (c < -64'sd1073741824) c = -64'sd1073741824;
		ang = acos_turn(c);
		rad = (ang * longint'(gcd_pkg::TWO_PI_Q29) + (64'd1 << 31)) >> 32;
		d = (rad * longint'(radius) + (64'd1 << 28)) >> 29;
		return d[24:0];
	endfunction

	// ---------------- checking ----------------

	task automatic report(string what, longint want, longint got);
		$display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, want, got);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (dist_queue.size() == 0) begin
				report("unexpected distance beat", -1, m_tdata[24:0]);
			end else if (m_tdata[24:0] !== dist_queue[0]) begin
				report("distance", dist_queue.pop_front(), m_tdata[24:0]);
			end else begin
				void'(dist_queue.pop_front());
			end
		end
	end

	// ---------------- receiver ----------------

	always @(negedge clk) begin
		if (recv_hold) begin
			m_tready = 1'b0;
		end else if (recv_quiet) begin
			m_tready = 1'b1;
		end else begin
			m_tready = ($urandom_range(99) >= 14);
		end
	end

	// ---------------- sender ----------------

	task automatic send_pair(point_pair_t p, longint typed_dist);
		if (!send_quiet && $urandom_range(99) < 14) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {2'b00, p.lon_b, p.lat_b[30:0], p.lon_a, p.lat_a[30:0]};
		do @(posedge clk); while (!s_tready);
		if (typed_dist == NO_CHECK) begin
			dist_queue.push_back(gc_distance(p, radius_now));
		end else begin
			dist_queue.push_back(typed_dist[24:0]);
		end
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic set_radius(logic [22:0] r);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (dist_queue.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = r;
		@(negedge clk);
		cfg_we = 1'b0;
		radius_now = r;
	endtask

	function automatic point_pair_t random_pair();
		point_pair_t p;
		case ($urandom_range(9))
			0: begin
				// Raw bit patterns, far outside the coordinate ranges.
				p.lat_a = $urandom(); p.lon_a = $urandom();
				p.lat_b = $urandom(); p.lon_b = $urandom();
			end
			1, 2: begin
				// Nearby points, short distances.
				p.lat_a = $urandom_range(2 * LAT_MAX) - LAT_MAX;
				p.lon_a = int'($urandom_range(2 * LON_MAX)) - LON_MAX;
				p.lat_b = p.lat_a + int'($urandom_range(20000)) - 10000;
				p.lon_b = p.lon_a + int'($urandom_range(20000)) - 10000;
			end
			3: begin
				// Close to antipodal.
				p.lat_a = $urandom_range(2 * LAT_MAX) - LAT_MAX;
				p.lon_a = int'($urandom_range(2 * LON_MAX)) - LON_MAX;
				p.lat_b = -p.lat_a + int'($urandom_range(2000)) - 1000;
				p.lon_b = p.lon_a + (p.lon_a < 0 ? LON_MAX : -LON_MAX)
					+ int'($urandom_range(2000)) - 1000;
			end
			default: begin
				p.lat_a = $urandom_range(2 * LAT_MAX) - LAT_MAX;
				p.lon_a = int'($urandom_range(2 * LON_MAX)) - LON_MAX;
				p.lat_b = $urandom_range(2 * LAT_MAX) - LAT_MAX;
				p.lon_b = int'($urandom_range(2 * LON_MAX)) - LON_MAX;
			end
		endcase
		return p;
	endfunction

	task automatic random_phase(int count);
		for (int n = 0; n < count; n++) begin
			send_pair(random_pair(), NO_CHECK);
		end
	endtask

	stim_row_t directed[$] = '{
		'{0, 0, '{0, 0, 0, 0}, NO_CHECK},
		'{0, 0, '{LAT_MAX, 0, -LAT_MAX, 0}, NO_CHECK},
		'{0, 0, '{LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX}, NO_CHECK},
		'{0, 0, '{0, LON_MAX, 0, -LON_MAX}, NO_CHECK},
		'{0, 0, '{0, 0, 0, LON_MAX}, NO_CHECK},
		'{0, 0, '{-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX}, NO_CHECK},
		'{0, 0, '{485000000, 23000000, -338000000, 1512000000}, NO_CHECK},
		'{0, 0, '{485000000, 23000000, 485000001, 23000001}, NO_CHECK},
		'{0, 0, '{-1073741824, 32'h80000000, 1073741823, 32'h7fffffff}, NO_CHECK},
		'{0, 0, '{1073741823, 32'h7fffffff, -1073741824, 32'h80000000}, NO_CHECK},
		'{0, 0, '{-1, -1, 0, 0}, NO_CHECK},
		'{0, 0, '{450000000, -900000000, -450000000, 900000000}, NO_CHECK},
		'{0, 0, '{123456789, -987654321, 123456789, -987654321}, NO_CHECK},
		// A radius of zero must always give zero.
		'{1, 23'd0, '{0, 0, 0, 0}, NO_CHECK},
		'{0, 0, '{LAT_MAX, 0, -LAT_MAX, 0}, 0},
		'{0, 0, '{0, LON_MAX, 0, 0}, 0},
		'{0, 0, '{-1073741824, 32'h80000000, 1073741823, 32'h7fffffff}, 0},
		'{1, 23'd1, '{0, 0, 0, 0}, NO_CHECK},
		'{0, 0, '{LAT_MAX, 0, -LAT_MAX, 0}, NO_CHECK},
		'{0, 0, '{0, 0, 0, LON_MAX}, NO_CHECK},
		'{1, 23'h7fffff, '{0, 0, 0, 0}, NO_CHECK},
		'{0, 0, '{LAT_MAX, 0, -LAT_MAX, 0}, NO_CHECK},
		'{0, 0, '{0, 0, 0, LON_MAX}, NO_CHECK},
		'{0, 0, '{-LAT_MAX, LON_MAX, 0, 0}, NO_CHECK}
	};

	// Long stall on the output so the pipeline fills and drops s_tready.
	initial begin
		wait (hold_go);
		repeat (100) @(posedge clk);
		recv_hold = 1'b1;
		repeat (600) @(posedge clk);
		recv_hold = 1'b0;
	end

	initial begin
		#10ms;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_cfg) begin
				set_radius(directed[i].radius);
			end else begin
				send_pair(directed[i].pair, directed[i].want);
			end
		end

		set_radius(gcd_pkg::RADIUS_RESET);
		hold_go = 1'b1;
		random_phase(400);
		send_quiet = 1'b1;
		recv_quiet = 1'b1;
		random_phase(300);
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
		random_phase(300);
		set_radius(23'h7fffff);
		random_phase(250);
		set_radius(23'd1);
		random_phase(150);
		set_radius(23'($urandom_range(23'h7fffff, 1)));
		random_phase(200);
		set_radius(23'd0);
		random_phase(60);

		while (dist_queue.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
